>>> sv/mck_pkg.sv
// Package of the Morse keyer: widths, unit codes, element table lookup.
package mck_pkg;

	localparam int TuW  = 16;
	localparam int DurW = 18;
	localparam int PatW = 15;
	localparam int LenW = 4;

	localparam logic [TuW-1:0] TU_RESET = 16'd1000;

	localparam logic [1:0] UNITS_1 = 2'd0;
	localparam logic [1:0] UNITS_2 = 2'd1;
	localparam logic [1:0] UNITS_3 = 2'd2;
	localparam logic [1:0] UNITS_4 = 2'd3;

	typedef struct packed {
		logic [LenW-1:0] len;
		logic [PatW-1:0] pat;
	} code_t;

	function automatic code_t mk_code(input logic [LenW-1:0] len, input logic [PatW-1:0] pat);
		code_t r;
		r.len = len;
		r.pat = pat << (4'(PatW) - len);
		return r;
	endfunction

	// left-align the elements, first element in the top bit, 1 = dash
	function automatic code_t lookup(input logic [7:0] ch);
		logic [7:0] c;
		code_t e;
		c = ch;
		if (c >= "A" && c <= "Z") c = c + 8'd32;
		e = '0;
		case (c)
			"a":    e = mk_code(4'd2, 15'h01);
			"b":    e = mk_code(4'd4, 15'h08);
			"c":    e = mk_code(4'd4, 15'h0A);
			"d":    e = mk_code(4'd3, 15'h04);
			"e":    e = mk_code(4'd1, 15'h00);
			8'hE9:  e = mk_code(4'd5, 15'h04);
			"f":    e = mk_code(4'd4, 15'h02);
			"g":    e = mk_code(4'd3, 15'h06);
			"h":    e = mk_code(4'd4, 15'h00);
			"i":    e = mk_code(4'd2, 15'h00);
			"j":    e = mk_code(4'd4, 15'h07);
			"k":    e = mk_code(4'd3, 15'h05);
			"l":    e = mk_code(4'd4, 15'h04);
			"m":    e = mk_code(4'd2, 15'h03);
			"n":    e = mk_code(4'd2, 15'h02);
			"o":    e = mk_code(4'd3, 15'h07);
			"p":    e = mk_code(4'd4, 15'h06);
			"q":    e = mk_code(4'd4, 15'h0D);
			"r":    e = mk_code(4'd3, 15'h02);
			"s":    e = mk_code(4'd3, 15'h00);
			"t":    e = mk_code(4'd1, 15'h01);
			"u":    e = mk_code(4'd3, 15'h01);
			"v":    e = mk_code(4'd4, 15'h01);
			"w":    e = mk_code(4'd3, 15'h03);
			"x":    e = mk_code(4'd4, 15'h09);
			"y":    e = mk_code(4'd4, 15'h0B);
			"z":    e = mk_code(4'd4, 15'h0C);
			"1":    e = mk_code(4'd5, 15'h0F);
			"2":    e = mk_code(4'd5, 15'h07);
			"3":    e = mk_code(4'd5, 15'h03);
			"4":    e = mk_code(4'd5, 15'h01);
			"5":    e = mk_code(4'd5, 15'h00);
			"6":    e = mk_code(4'd5, 15'h10);
			"7":    e = mk_code(4'd5, 15'h18);
			"8":    e = mk_code(4'd5, 15'h1C);
			"9":    e = mk_code(4'd5, 15'h1E);
			"0":    e = mk_code(4'd5, 15'h1F);
			".":    e = mk_code(4'd6, 15'h15);
			",":    e = mk_code(4'd6, 15'h33);
			":":    e = mk_code(4'd6, 15'h38);
			"?":    e = mk_code(4'd6, 15'h0C);
			"'":    e = mk_code(4'd6, 15'h1E);
			"-":    e = mk_code(4'd6, 15'h21);
			"/":    e = mk_code(4'd5, 15'h12);
			"(":    e = mk_code(4'd5, 15'h16);
			")":    e = mk_code(4'd6, 15'h2D);
			"\"":   e = mk_code(4'd6, 15'h12);
			"=":    e = mk_code(4'd5, 15'h11);
			"+":    e = mk_code(4'd5, 15'h0A);
			"@":    e = mk_code(4'd6, 15'h1A);
			"%":    e = mk_code(4'd15, 15'h7E5F);
			default: e = '0;
		endcase
		return e;
	endfunction

endpackage

>>> sv/mck_if.sv
// Channel interfaces of the Morse keyer: character beats and key segment beats.
interface mck_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       word_end;

	modport source (output valid, output char_code, output word_end, input ready);
	modport sink   (input valid, input char_code, input word_end, output ready);
endinterface

interface mck_out_if;
	logic        valid;
	logic        ready;
	logic        key_on;
	logic [17:0] duration;
	logic        last_segment;

	modport source (output valid, output key_on, output duration, output last_segment,
		input ready);
	modport sink   (input valid, input key_on, input duration, input last_segment,
		output ready);
endinterface

>>> sv/mck_dur.sv
// Shared duration unit: unit count times the configured time unit.
module mck_dur (
	input  logic [mck_pkg::TuW-1:0]  time_unit,
	input  logic [1:0]               units,
	output logic [mck_pkg::DurW-1:0] duration
);
	import mck_pkg::*;

	logic [DurW-1:0] x1;
	logic [DurW-1:0] x2;

	assign x1 = {2'b00, time_unit};
	assign x2 = {1'b0, time_unit, 1'b0};

	always_comb begin
		case (units)
			UNITS_1: duration = x1;
			UNITS_2: duration = x2;
			UNITS_3: duration = x2 + x1;
			UNITS_4: duration = {time_unit, 2'b00};
			default: duration = x1;
		endcase
	end

endmodule

>>> sv/morse_character_keyer_unit.sv
// Top level of the Morse keyer: character intake, segment sequencer, output register.
//
// Usage:
//   chars carries one beat per character (char_code, word_end). segs carries one
//   beat per key segment (key_on, duration in ms, last_segment on the final one).
//   cfg_we/cfg_data write the time unit in ms; write only while the block is idle.
// Timing:
//   A character is taken when chars.ready is high, which happens only while the
//   sequencer is idle. Its segments pass through the output register, one per
//   cycle while segs.ready is high: 2*elements + 1 segments, one more when
//   word_end is set, at most 32. The sequencer and its single duration unit issue
//   every segment; the next character is taken only once the last one is issued.
// Reset:
//   arst_n clears the sequencer and the output valid, and sets the time unit to
//   1000 ms.
// Stall:
//   While segs.ready is low with a beat pending, the output register holds it and
//   the sequencer waits; nothing is dropped.
module morse_character_keyer_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	mck_in_if.sink                  chars,
	mck_out_if.source               segs,
	input  logic                    cfg_we,
	input  logic [mck_pkg::TuW-1:0] cfg_data
);
	import mck_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ON   = 3'd1;
	localparam logic [2:0] ST_OFF  = 3'd2;
	localparam logic [2:0] ST_GAP2 = 3'd3;
	localparam logic [2:0] ST_GAP4 = 3'd4;

	logic [2:0]      state_q;
	logic [TuW-1:0]  tu_q;
	logic [PatW-1:0] pat_q;
	logic [LenW-1:0] cnt_q;
	logic            we_q;

	logic            seg_valid_q;
	logic            key_on_q;
	logic [DurW-1:0] dur_q;
	logic            last_q;

	code_t           code;
	logic            take;
	logic            adv;
	logic [1:0]      units;
	logic            key_on_d;
	logic            last_d;
	logic [DurW-1:0] dur_d;

	assign code  = lookup(chars.char_code);
	assign chars.ready = (state_q == ST_IDLE);
	assign take  = chars.valid && chars.ready;
	assign adv   = (state_q != ST_IDLE) && (!seg_valid_q || segs.ready);

	always_comb begin
		units    = UNITS_1;
		key_on_d = 1'b0;
		last_d   = 1'b0;
		case (state_q)
			ST_ON: begin
				key_on_d = 1'b1;
				units    = pat_q[PatW-1] ? UNITS_3 : UNITS_1;
			end
			ST_OFF: begin
				units = UNITS_1;
			end
			ST_GAP2: begin
				units  = UNITS_2;
				last_d = !we_q;
			end
			ST_GAP4: begin
				units  = UNITS_4;
				last_d = 1'b1;
			end
			default: begin
				units = UNITS_1;
			end
		endcase
	end

	mck_dur u_dur (
		.time_unit (tu_q),
		.units     (units),
		.duration  (dur_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tu_q <= TU_RESET;
		end else if (cfg_we) begin
			tu_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) state_q <= (code.len != '0) ? ST_ON : ST_GAP2;
				end
				ST_ON: begin
					if (adv) state_q <= ST_OFF;
				end
				ST_OFF: begin
					if (adv) state_q <= (cnt_q == 4'd1) ? ST_GAP2 : ST_ON;
				end
				ST_GAP2: begin
					if (adv) state_q <= we_q ? ST_GAP4 : ST_IDLE;
				end
				ST_GAP4: begin
					if (adv) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pat_q <= code.pat;
			cnt_q <= code.len;
			we_q  <= chars.word_end;
		end else if (adv && state_q == ST_OFF) begin
			pat_q <= pat_q << 1;
			cnt_q <= cnt_q - 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_valid_q <= 1'b0;
		end else if (adv) begin
			seg_valid_q <= 1'b1;
		end else if (segs.ready) begin
			seg_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			key_on_q <= key_on_d;
			dur_q    <= dur_d;
			last_q   <= last_d;
		end
	end

	assign segs.valid        = seg_valid_q;
	assign segs.key_on       = key_on_q;
	assign segs.duration     = dur_q;
	assign segs.last_segment = last_q;

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (state_q != ST_IDLE))
		else $error("sequencer idle right after a character beat");

	a_last_is_gap: assert property (@(posedge clk) disable iff (!arst_n)
		segs.valid && segs.key_on |-> !segs.last_segment)
		else $error("final segment marked on a key-on segment");

	a_no_take_while_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GAP2 || state_q == ST_GAP4) |-> !chars.ready)
		else $error("character taken before the gaps were sent");

	a_off_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ON || state_q == ST_OFF) |-> (cnt_q != '0))
		else $error("element sequencer running with no elements left");

endmodule
